FILE: rtl/alte_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alte_pkg: shared definitions for the ordered list table engine
// Sizes, request and status codes, and the per-cell control bundle.
// ----------------------------------------------------------------------------
package alte_pkg;

  localparam int CAPACITY  = 64;
  localparam int WORD_BITS = 32;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [1:0] {
    KIND_APPEND = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_DELETE = 2'd2,
    KIND_SEARCH = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_REJECT = 2'd1,
    ST_MISS   = 2'd2
  } status_t;

  // What a cell loads at the next edge
  typedef enum logic [1:0] {
    CELL_HOLD    = 2'd0,
    CELL_LOAD    = 2'd1,
    CELL_TAKE_LO = 2'd2,
    CELL_TAKE_HI = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     cmp_en;
  } cell_ctrl_t;

  // Bring a 32-bit request word into the stored width
  function automatic word_t to_word(input logic [31:0] v);
    word_t w;
    w = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      w[i] = (i < 32) ? v[i] : 1'b0;
    end
    return w;
  endfunction

  // Bring a stored word out to the 32-bit result field
  function automatic logic [31:0] to_out(input word_t w);
    logic [31:0] v;
    v = '0;
    for (int i = 0; i < 32; i++) begin
      v[i] = (i < WORD_BITS) ? w[i] : 1'b0;
    end
    return v;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/alte_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alte_in_if: request channel
// Valid/ready channel carrying one list request.
// ----------------------------------------------------------------------------
interface alte_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [6:0]         position;
  logic signed [31:0] value;

  modport source (output valid, kind, position, value, input ready);
  modport sink   (input valid, kind, position, value, output ready);
endinterface
`default_nettype wire

FILE: rtl/alte_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alte_out_if: result channel
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
interface alte_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] read_value;
  logic [5:0]         found_at;
  logic [6:0]         fill;

  modport source (output valid, status, read_value, found_at, fill, input ready);
  modport sink   (input valid, status, read_value, found_at, fill, output ready);
endinterface
`default_nettype wire

FILE: rtl/alte_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alte_cell: one list slot
// Holds one word, loads a new word or a neighbor's word, and registers
// an equality compare against the search key.
// ----------------------------------------------------------------------------
module alte_cell (
  input  wire                 clk,
  input  alte_pkg::cell_ctrl_t ctrl,
  input  alte_pkg::word_t     new_word,
  input  alte_pkg::word_t     key,
  input  alte_pkg::word_t     lo_word,
  input  alte_pkg::word_t     hi_word,
  output alte_pkg::word_t     word,
  output logic                match
);

  alte_pkg::word_t word_r;
  alte_pkg::word_t word_nxt;
  logic            match_r;

  always_comb begin
    unique case (ctrl.op)
      alte_pkg::CELL_HOLD:    word_nxt = word_r;
      alte_pkg::CELL_LOAD:    word_nxt = new_word;
      alte_pkg::CELL_TAKE_LO: word_nxt = lo_word;
      alte_pkg::CELL_TAKE_HI: word_nxt = hi_word;
      default:                word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    if (ctrl.cmp_en) begin
      match_r <= (word_r == key);
    end
  end

  assign word  = word_r;
  assign match = match_r;

endmodule
`default_nettype wire

FILE: rtl/array_list_table_engine_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// array_list_table_engine_unit: dense ordered list with transposition search
// Append, insert, delete and search over a row of word cells that shift
// toward their neighbors.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  in_chan   in   valid/ready    kind, position, value
//  out_chan  out  valid/ready    status, read_value, found_at, fill
//  cfg_*     in   cfg_we         cfg_data = capacity_in_use
//
// Each request passes an accept step, a compare step in which every cell
// registers its key match and the delete word is picked, and an apply step
// in which the cells shift or swap. The apply step waits while a previous
// result is still untaken. Reset clears the fill count and sets the capacity
// limit to 64; cell contents need no reset.
// ----------------------------------------------------------------------------
module array_list_table_engine_unit (
  input  wire              clk,
  input  wire              rst_n,
  alte_in_if.sink          in_chan,
  alte_out_if.source       out_chan,
  input  wire              cfg_we,
  input  wire [6:0]        cfg_data
);

  localparam int N     = alte_pkg::CAPACITY;
  localparam int CNT_W = alte_pkg::CNT_W;
  localparam int IDX_W = alte_pkg::IDX_W;
  localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_APPLY
  } state_t;

  state_t                 state_r;
  alte_pkg::kind_t        kind_r;
  logic [6:0]             pos_r;
  alte_pkg::word_t        key_r;
  logic [CNT_W-1:0]       count_r;
  logic [CNT_W-1:0]       count_nxt;
  logic [6:0]             cap_r;
  alte_pkg::word_t        sel_r;
  alte_pkg::word_t        sel_nxt;

  logic                   out_valid_r;
  alte_pkg::status_t      out_status_r;
  logic [31:0]            out_rd_r;
  logic [5:0]             out_found_r;
  logic [6:0]             out_fill_r;

  alte_pkg::cell_ctrl_t   ctrl   [N];
  alte_pkg::word_t        words  [N];
  logic [N-1:0]           match;
  logic [N-1:0]           hit;
  logic [N-1:0]           lower_hit;
  logic [N-1:0]           first;

  logic [CMP_W-1:0]       pos_e;
  logic [CMP_W-1:0]       cnt_e;
  logic [CMP_W-1:0]       lim_e;
  logic                   room;
  logic                   go;
  logic                   found;
  logic [IDX_W-1:0]       where;
  alte_pkg::status_t      status_nxt;
  logic [31:0]            rd_nxt;

  assign in_chan.ready = (state_r == S_IDLE);

  assign pos_e = CMP_W'(pos_r);
  assign cnt_e = CMP_W'(count_r);
  assign lim_e = (CMP_W'(cap_r) < CMP_W'(N)) ? CMP_W'(cap_r) : CMP_W'(N);
  assign room  = (cnt_e < lim_e);
  assign go    = (state_r == S_APPLY) && (!out_valid_r || out_chan.ready);

  // Only live entries may match; first hit wins via a prefix-OR
  always_comb begin
    for (int i = 0; i < N; i++) begin
      hit[i] = match[i] && (CMP_W'(i) < cnt_e);
    end
    lower_hit = hit << 1;
    for (int s = 1; s < N; s = s * 2) begin
      lower_hit = lower_hit | (lower_hit << s);
    end
    first = hit & ~lower_hit;
    found = |hit;
    where = '0;
    for (int i = 1; i < N; i++) begin
      if (first[i]) begin
        where = where | IDX_W'(i - 1);
      end
    end
  end

  // Pick the word under position for a delete
  always_comb begin
    sel_nxt = '0;
    for (int i = 0; i < N; i++) begin
      if (pos_e == CMP_W'(i)) begin
        sel_nxt = sel_nxt | words[i];
      end
    end
  end

  // Per-cell moves and the result of the request
  always_comb begin
    status_nxt = alte_pkg::ST_DONE;
    rd_nxt     = '0;
    count_nxt  = count_r;
    for (int i = 0; i < N; i++) begin
      ctrl[i].op     = alte_pkg::CELL_HOLD;
      ctrl[i].cmp_en = (state_r == S_CMP);
    end
    unique case (kind_r)
      alte_pkg::KIND_APPEND: begin
        if (room) begin
          count_nxt = count_r + CNT_W'(1);
          for (int i = 0; i < N; i++) begin
            if (go && CMP_W'(i) == cnt_e) ctrl[i].op = alte_pkg::CELL_LOAD;
          end
        end else begin
          status_nxt = alte_pkg::ST_REJECT;
        end
      end
      alte_pkg::KIND_INSERT: begin
        if (room && pos_e <= cnt_e) begin
          count_nxt = count_r + CNT_W'(1);
          for (int i = 0; i < N; i++) begin
            if (go && CMP_W'(i) == pos_e) begin
              ctrl[i].op = alte_pkg::CELL_LOAD;
            end else if (go && CMP_W'(i) > pos_e && CMP_W'(i) <= cnt_e) begin
              ctrl[i].op = alte_pkg::CELL_TAKE_LO;
            end
          end
        end else begin
          status_nxt = alte_pkg::ST_REJECT;
        end
      end
      alte_pkg::KIND_DELETE: begin
        if (pos_e < cnt_e) begin
          count_nxt = count_r - CNT_W'(1);
          rd_nxt    = alte_pkg::to_out(sel_r);
          for (int i = 0; i < N; i++) begin
            if (go && CMP_W'(i) >= pos_e && CMP_W'(i) + CMP_W'(1) < cnt_e) begin
              ctrl[i].op = alte_pkg::CELL_TAKE_HI;
            end
          end
        end else begin
          status_nxt = alte_pkg::ST_REJECT;
        end
      end
      alte_pkg::KIND_SEARCH: begin
        if (found) begin
          // Swap the hit with its predecessor
          for (int i = 1; i < N; i++) begin
            if (go && first[i]) ctrl[i].op = alte_pkg::CELL_TAKE_LO;
            if (go && first[i]) ctrl[i-1].op = alte_pkg::CELL_TAKE_HI;
          end
        end else begin
          status_nxt = alte_pkg::ST_MISS;
        end
      end
      default: status_nxt = alte_pkg::ST_REJECT;
    endcase
  end

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      alte_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl[g]),
        .new_word (key_r),
        .key      (key_r),
        .lo_word  (words[(g > 0) ? g - 1 : g]),
        .hi_word  (words[(g < N - 1) ? g + 1 : g]),
        .word     (words[g]),
        .match    (match[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cap_r       <= 7'd64;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) cap_r <= cfg_data;
      if (go) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_chan.valid) begin
            kind_r  <= alte_pkg::kind_t'(in_chan.kind);
            pos_r   <= in_chan.position;
            key_r   <= alte_pkg::to_word(in_chan.value);
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          sel_r   <= sel_nxt;
          state_r <= S_APPLY;
        end
        S_APPLY: begin
          // Hold until the result register is free
          if (go) begin
            count_r      <= count_nxt;
            out_status_r <= status_nxt;
            out_rd_r     <= rd_nxt;
            out_found_r  <= (kind_r == alte_pkg::KIND_SEARCH && found) ? 6'(where) : 6'd0;
            out_fill_r   <= 7'(count_nxt);
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.status     = out_status_r;
  assign out_chan.read_value = out_rd_r;
  assign out_chan.found_at   = out_found_r;
  assign out_chan.fill       = out_fill_r;

endmodule
`default_nettype wire

FILE: sim/alte_list_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alte_list_checker: result checker for the ordered list table engine
// Watches the request, result and capacity ports, keeps its own copy of the
// list to predict every result, and compares each result in arrival order.
// ----------------------------------------------------------------------------
module alte_list_checker
  import alte_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  alte_in_if         req,
  alte_out_if        rsp,
  input  wire        cfg_we,
  input  wire [6:0]  cfg_data,
  output int         mismatch_count,
  output int         pending_results,
  output int         results_checked,
  output int         list_fill
);

  typedef struct packed {
    status_t          status;
    logic [31:0]      read_value;
    logic [5:0]       found_at;
    logic [6:0]       fill;
  } list_result_t;

  word_t        shadow_list [CAPACITY];
  int           shadow_count = 0;
  logic [6:0]   cap_limit_reg = 7'd64;
  list_result_t awaited_results [$];

  // Apply one request to the shadow list and return the result it must produce
  function automatic list_result_t apply_request(kind_t k, logic [6:0] p, word_t v);
    list_result_t r;
    int           lim;
    int           hit;
    word_t        tmp;
    r = '0;
    r.status = ST_DONE;
    lim = (cap_limit_reg < CAPACITY) ? int'(cap_limit_reg) : CAPACITY;
    hit = -1;
    case (k)
      KIND_APPEND: begin
        if (shadow_count < lim) begin
          shadow_list[shadow_count] = v;
          shadow_count++;
        end else begin
          r.status = ST_REJECT;
        end
      end
      KIND_INSERT: begin
        if (shadow_count < lim && int'(p) <= shadow_count) begin
          for (int i = shadow_count; i > int'(p); i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[int'(p)] = v;
          shadow_count++;
        end else begin
          r.status = ST_REJECT;
        end
      end
      KIND_DELETE: begin
        if (int'(p) < shadow_count) begin
          r.read_value = shadow_list[int'(p)];
          for (int i = int'(p); i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
          shadow_count--;
        end else begin
          r.status = ST_REJECT;
        end
      end
      default: begin
        r.status = ST_MISS;
        for (int i = 0; i < shadow_count; i++) begin
          if (hit < 0 && shadow_list[i] == v) hit = i;
        end
        if (hit >= 0) begin
          r.status = ST_DONE;
          // transpose with the predecessor; a front hit stays put
          if (hit > 0) begin
            tmp                 = shadow_list[hit];
            shadow_list[hit]    = shadow_list[hit-1];
            shadow_list[hit-1]  = tmp;
            r.found_at          = 6'(hit - 1);
          end
        end
      end
    endcase
    r.fill = 7'(shadow_count);
    return r;
  endfunction

  always @(posedge clk) begin
    list_result_t exp_res;
    if (!rst_n) begin
      shadow_count  = 0;
      cap_limit_reg = 7'd64;
      awaited_results.delete();
    end else begin
      if (cfg_we) cap_limit_reg = cfg_data;
      // take the result before the request so a same-edge transfer cannot match itself
      if (rsp.valid && rsp.ready) begin
        if (awaited_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("[%0t] result with nothing awaited: status=%0d read_value=%0d found_at=%0d fill=%0d",
                     $realtime, rsp.status, $signed(rsp.read_value), rsp.found_at, rsp.fill);
        end else begin
          exp_res = awaited_results.pop_front();
          results_checked++;
          if (exp_res.status !== rsp.status || exp_res.read_value !== rsp.read_value ||
              exp_res.found_at !== rsp.found_at || exp_res.fill !== rsp.fill) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("[%0t] mismatch: expected status=%0d read_value=%0d found_at=%0d fill=%0d",
                       $realtime, exp_res.status, $signed(exp_res.read_value),
                       exp_res.found_at, exp_res.fill);
              $display("[%0t]           got status=%0d read_value=%0d found_at=%0d fill=%0d",
                       $realtime, rsp.status, $signed(rsp.read_value), rsp.found_at, rsp.fill);
            end
          end
        end
      end
      if (req.valid && req.ready)
        awaited_results.push_back(apply_request(kind_t'(req.kind), req.position, req.value));
    end
    pending_results = awaited_results.size();
    list_fill       = shadow_count;
  end

endmodule

FILE: sim/array_list_table_engine_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_list_table_engine_unit_test: testbench for the ordered list engine
// Drives directed corner requests and biased random request streams under
// several capacity limits, with random stalls on both channels; the checker
// beside the engine predicts and compares every result.
// ----------------------------------------------------------------------------
module array_list_table_engine_unit_test;
  import alte_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 10;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [6:0] cfg_data;
  logic       steady = 1'b0;
  int         idle_cycles = 0;
  int         kind_tally [4];
  int         cap_writes = 0;
  word_t      key_pool [16];

  int mismatch_count, pending_results, results_checked, list_fill;

  alte_in_if  in_chan ();
  alte_out_if out_chan ();

  array_list_table_engine_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  alte_list_checker list_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .req             (in_chan),
    .rsp             (out_chan),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results),
    .results_checked (results_checked),
    .list_fill       (list_fill)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Count cycles in which neither channel completes a transfer
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("FAIL");
    $finish;
  end

  // Result side back-pressure
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_chan.ready <= steady || ($urandom_range(99) >= 31);
    end
  end

  task automatic write_cap(input logic [6:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we   <= 1'b0;
    cap_writes++;
  endtask

  // Leaves valid high on return; the next call or drain decides its value
  task automatic send_req(input kind_t k, input logic [6:0] p, input word_t v);
    while (!steady && $urandom_range(99) < 31) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid    <= 1'b1;
    in_chan.kind     <= k;
    in_chan.position <= p;
    in_chan.value    <= v;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    kind_tally[k]++;
    @(negedge clk);
  endtask

  // Hold the sender until every awaited result has arrived
  task automatic drain();
    in_chan.valid <= 1'b0;
    @(negedge clk);
    while (pending_results != 0) @(negedge clk);
  endtask

  task automatic rand_req(input int w_app, input int w_ins, input int w_del);
    int         roll;
    kind_t      k;
    logic [6:0] p;
    word_t      v;
    roll = $urandom_range(99);
    if (roll < w_app)                    k = KIND_APPEND;
    else if (roll < w_app + w_ins)         k = KIND_INSERT;
    else if (roll < w_app + w_ins + w_del) k = KIND_DELETE;
    else                                   k = KIND_SEARCH;
    roll = $urandom_range(9);
    if (roll < 7)       p = 7'($urandom_range(list_fill));
    else if (roll < 8)  p = 7'(list_fill + 1);
    else                p = 7'($urandom_range(127));
    // draw mostly from a small pool so searches hit
    if ($urandom_range(9) < 6) v = key_pool[$urandom_range(15)];
    else                       v = $urandom();
    send_req(k, p, v);
  endtask

  task automatic run_phase(input logic [6:0] cap, input int count,
                           input int w_app, input int w_ins, input int w_del);
    drain();
    write_cap(cap);
    repeat (count) rand_req(w_app, w_ins, w_del);
  endtask

  initial begin
    in_chan.valid    = 1'b0;
    in_chan.kind     = KIND_APPEND;
    in_chan.position = '0;
    in_chan.value    = '0;
    cfg_we           = 1'b0;
    cfg_data         = '0;
    rst_n            = 1'b0;
    foreach (kind_tally[i]) kind_tally[i] = 0;
    key_pool[0] = 32'h7FFF_FFFF;
    key_pool[1] = 32'h8000_0000;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < 16; i++) key_pool[i] = $urandom();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    write_cap(7'd64);

    // Empty list corners, then extremes and transposition at both ends
    send_req(KIND_SEARCH, 7'd0,   32'd5);
    send_req(KIND_DELETE, 7'd0,   32'd0);
    send_req(KIND_INSERT, 7'd1,   32'd1);
    send_req(KIND_APPEND, 7'd0,   32'h7FFF_FFFF);
    send_req(KIND_APPEND, 7'd0,   32'h8000_0000);
    send_req(KIND_INSERT, 7'd0,   32'h0000_0000);
    send_req(KIND_INSERT, 7'd3,   32'hFFFF_FFFF);
    send_req(KIND_INSERT, 7'd127, 32'd2);
    send_req(KIND_SEARCH, 7'd0,   32'h0000_0000);
    send_req(KIND_SEARCH, 7'd0,   32'hFFFF_FFFF);
    send_req(KIND_SEARCH, 7'd0,   32'd12345);
    send_req(KIND_DELETE, 7'd127, 32'd0);
    send_req(KIND_DELETE, 7'd3,   32'd0);
    send_req(KIND_APPEND, 7'd0,   32'h55AA_55AA);

    // Limit dropped below the fill: growth rejected until deletes catch up
    drain();
    write_cap(7'd2);
    send_req(KIND_APPEND, 7'd0, 32'd1);
    send_req(KIND_INSERT, 7'd0, 32'd1);
    send_req(KIND_SEARCH, 7'd0, 32'h55AA_55AA);
    send_req(KIND_DELETE, 7'd0, 32'd0);
    send_req(KIND_DELETE, 7'd0, 32'd0);
    send_req(KIND_APPEND, 7'd0, 32'd3);
    send_req(KIND_DELETE, 7'd1, 32'd0);
    send_req(KIND_APPEND, 7'd0, 32'd3);

    drain();
    write_cap(7'd0);
    send_req(KIND_APPEND, 7'd0, 32'd4);
    send_req(KIND_INSERT, 7'd0, 32'd4);
    send_req(KIND_DELETE, 7'd0, 32'd0);

    // Random streams: grow to full, shrink under tight limits, regrow
    drain();
    steady = 1'b1;
    run_phase(7'd64, 70, 40, 25, 10);
    drain();
    steady = 1'b0;
    run_phase(7'd127, 130, 40, 25, 10);
    run_phase(7'd0, 60, 20, 20, 60);
    run_phase(7'd5, 100, 30, 20, 25);
    run_phase(7'd1, 40, 30, 20, 25);
    run_phase(7'd64, 100, 20, 20, 35);

    drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Covered %0d requests: %0d appends, %0d inserts, %0d deletes, %0d searches",
             kind_tally[0] + kind_tally[1] + kind_tally[2] + kind_tally[3],
             kind_tally[KIND_APPEND], kind_tally[KIND_INSERT],
             kind_tally[KIND_DELETE], kind_tally[KIND_SEARCH]);
    $display("%0d results checked over %0d capacity writes, %0d mismatches, %0d outstanding",
             results_checked, cap_writes, mismatch_count, pending_results);
    if (mismatch_count == 0 && pending_results == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

FILE: array_list_table_engine_unit.f
rtl/alte_pkg.sv
rtl/alte_in_if.sv
rtl/alte_out_if.sv
rtl/alte_cell.sv
rtl/array_list_table_engine_unit.sv
sim/alte_list_checker.sv
sim/array_list_table_engine_unit_test.sv
